>>> sv/msm_pkg.sv
`default_nettype none

package msm_pkg;

  // Fixed field widths.
  localparam int CodeW    = 12;
  localparam int SlotW    = 2;
  localparam int ThreshW  = 48;
  localparam int EnableW  = 4;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 48;

  // Default sizing of the per-slot storage.
  localparam int DefSlotCount    = 4;
  localparam int DefHistoryDepth = 16;

  // Configuration register reset values.
  localparam logic [ThreshW-1:0] LowThreshReset  = '0;
  localparam logic [ThreshW-1:0] HighThreshReset = '1;
  localparam logic [CodeW-1:0]   ChangeThrReset  = CodeW'(16);
  localparam logic [EnableW-1:0] EnableReset     = '0;
  localparam logic [CodeW-1:0]   FullScale       = '1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LOW_THRESH  = 3'd0,
    CFG_HIGH_THRESH = 3'd1,
    CFG_CHANGE_THR  = 3'd2,
    CFG_CHAN_ENABLE = 3'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_DIVIDE,
    ST_OUTPUT
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic mem_read;
    logic update;
    logic out_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic item_ok;
    logic div_done;
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic [SlotW-1:0] result_slot;
    logic [CodeW-1:0] current_code;
    logic [CodeW-1:0] minimum_code;
    logic [CodeW-1:0] maximum_code;
    logic [CodeW-1:0] average_code;
    logic [CodeW-1:0] change_size;
    logic             changed;
    logic             above_high;
    logic             below_low;
  } result_t;

endpackage

`default_nettype wire

>>> sv/msm_sample_if.sv
`default_nettype none

interface msm_sample_if import msm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SlotW-1:0] slot;
  logic [CodeW-1:0] sample_code;

  modport source (output valid, output slot, output sample_code, input ready);
  modport sink   (input valid, input slot, input sample_code, output ready);
endinterface

`default_nettype wire

>>> sv/msm_result_if.sv
`default_nettype none

interface msm_result_if import msm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SlotW-1:0] result_slot;
  logic [CodeW-1:0] current_code;
  logic [CodeW-1:0] minimum_code;
  logic [CodeW-1:0] maximum_code;
  logic [CodeW-1:0] average_code;
  logic [CodeW-1:0] change_size;
  logic             changed;
  logic             above_high;
  logic             below_low;

  modport source (
    output valid, output result_slot, output current_code, output minimum_code,
    output maximum_code, output average_code, output change_size, output changed,
    output above_high, output below_low, input ready
  );
  modport sink (
    input valid, input result_slot, input current_code, input minimum_code,
    input maximum_code, input average_code, input change_size, input changed,
    input above_high, input below_low, output ready
  );
endinterface

`default_nettype wire

>>> sv/msm_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module msm_div #(
  parameter int DividendW = 17,
  parameter int DivisorW  = 5
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [DividendW-1:0] dividend_i,
  input  wire logic [DivisorW-1:0]  divisor_i,
  output logic                      busy_o,
  output logic [DividendW-1:0]      quotient_o
);

  localparam int CntW = $clog2(DividendW + 1);

  logic                 busy_q, busy_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [DividendW-1:0] quo_q, quo_d;
  logic [DivisorW-1:0]  rem_q, rem_d;
  logic [DivisorW-1:0]  dsr_q, dsr_d;
  logic [DivisorW:0]    rem_shift;
  logic [DivisorW:0]    rem_sub;
  logic                 fits;

  always_comb begin
    rem_shift = {rem_q, quo_q[DividendW-1]};
    rem_sub   = rem_shift - {1'b0, dsr_q};
    fits      = rem_shift >= {1'b0, dsr_q};
    busy_d    = busy_q;
    cnt_d     = cnt_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    dsr_d     = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DividendW);
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DividendW-2:0], fits};
      rem_d = fits ? rem_sub[DivisorW-1:0] : rem_shift[DivisorW-1:0];
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

>>> sv/msm_datapath.sv
`default_nettype none

module msm_datapath import msm_pkg::*; #(
  parameter int SLOT_COUNT    = DefSlotCount,
  parameter int HISTORY_DEPTH = DefHistoryDepth
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire logic [SlotW-1:0]    in_slot_i,
  input  wire logic [CodeW-1:0]    in_code_i,
  input  wire logic                out_ready_i,
  input  wire ctrl_cmd_t           cmd_i,
  output dp_status_t               status_o,
  output logic                     out_valid_o,
  output result_t                  result_o
);

  localparam int SlotIdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int PosW     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int FillW    = $clog2(HISTORY_DEPTH + 1);
  localparam int SumW     = CodeW + FillW;
  localparam int AddrW    = SlotIdxW + PosW;
  localparam int MemDepth = 1 << AddrW;

  // Configuration registers.
  logic [ThreshW-1:0] low_thr_q, high_thr_q;
  logic [CodeW-1:0]   change_thr_q;
  logic [EnableW-1:0] enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_thr_q    <= LowThreshReset;
      high_thr_q   <= HighThreshReset;
      change_thr_q <= ChangeThrReset;
      enable_q     <= EnableReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_LOW_THRESH:  low_thr_q    <= cfg_wdata_i[ThreshW-1:0];
        CFG_HIGH_THRESH: high_thr_q   <= cfg_wdata_i[ThreshW-1:0];
        CFG_CHANGE_THR:  change_thr_q <= cfg_wdata_i[CodeW-1:0];
        CFG_CHAN_ENABLE: enable_q     <= cfg_wdata_i[EnableW-1:0];
        default: ;
      endcase
    end
  end

  // Captured item.
  logic [SlotW-1:0]    slot_q;
  logic [CodeW-1:0]    code_q;
  logic [SlotIdxW-1:0] sidx;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      slot_q <= in_slot_i;
      code_q <= in_code_i;
    end
  end

  assign sidx = SlotIdxW'(slot_q);

  // Per-slot state.
  logic [PosW-1:0]  pos_q   [SLOT_COUNT];
  logic [FillW-1:0] fill_q  [SLOT_COUNT];
  logic [SumW-1:0]  sum_q   [SLOT_COUNT];
  logic [CodeW-1:0] lo_q    [SLOT_COUNT];
  logic [CodeW-1:0] hi_q    [SLOT_COUNT];
  logic [CodeW-1:0] prev_q  [SLOT_COUNT];
  logic             first_q [SLOT_COUNT];

  // History memory, one ring of entries per slot.
  logic [CodeW-1:0] mem_q [MemDepth];
  logic [CodeW-1:0] mem_rdata_q;
  logic [AddrW-1:0] mem_addr;

  assign mem_addr = {sidx, pos_q[sidx]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_read) begin
      mem_rdata_q <= mem_q[mem_addr];
    end
    if (cmd_i.update) begin
      mem_q[mem_addr] <= code_q;
    end
  end

  // Update arithmetic for the captured item.
  logic             full;
  logic [FillW-1:0] fill_new;
  logic [SumW-1:0]  sum_new;
  logic [PosW-1:0]  pos_new;
  logic [CodeW-1:0] lo_new, hi_new, delta;
  logic             chg;
  logic [CodeW-1:0] high_code, low_code;

  always_comb begin
    full     = 32'(fill_q[sidx]) >= HISTORY_DEPTH;
    fill_new = full ? fill_q[sidx] : fill_q[sidx] + FillW'(1);
    sum_new  = sum_q[sidx] - (full ? SumW'(mem_rdata_q) : '0) + SumW'(code_q);
    pos_new  = (32'(pos_q[sidx]) == HISTORY_DEPTH - 1) ? '0 : pos_q[sidx] + PosW'(1);
    lo_new   = (code_q < lo_q[sidx]) ? code_q : lo_q[sidx];
    hi_new   = (code_q > hi_q[sidx]) ? code_q : hi_q[sidx];
    if (first_q[sidx]) begin
      delta = '0;
      chg   = 1'b0;
    end else begin
      delta = (code_q >= prev_q[sidx]) ? code_q - prev_q[sidx] : prev_q[sidx] - code_q;
      chg   = delta >= change_thr_q;
    end
    high_code = high_thr_q[slot_q*CodeW +: CodeW];
    low_code  = low_thr_q[slot_q*CodeW +: CodeW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        pos_q[i]   <= '0;
        fill_q[i]  <= '0;
        sum_q[i]   <= '0;
        lo_q[i]    <= FullScale;
        hi_q[i]    <= '0;
        prev_q[i]  <= '0;
        first_q[i] <= 1'b1;
      end
    end else if (cmd_i.update) begin
      pos_q[sidx]   <= pos_new;
      fill_q[sidx]  <= fill_new;
      sum_q[sidx]   <= sum_new;
      lo_q[sidx]    <= lo_new;
      hi_q[sidx]    <= hi_new;
      prev_q[sidx]  <= code_q;
      first_q[sidx] <= 1'b0;
    end
  end

  // Mean over the filled entries.
  logic            div_busy;
  logic [SumW-1:0] quotient;

  msm_div #(
    .DividendW (SumW),
    .DivisorW  (FillW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.update),
    .dividend_i (sum_new),
    .divisor_i  (fill_new),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  // Result fields held while the division runs.
  result_t work_q, res_q, res_d;
  logic    out_valid_q;

  always_comb begin
    res_d              = work_q;
    res_d.average_code = quotient[CodeW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      work_q.result_slot  <= slot_q;
      work_q.current_code <= code_q;
      work_q.minimum_code <= lo_new;
      work_q.maximum_code <= hi_new;
      work_q.average_code <= '0;
      work_q.change_size  <= delta;
      work_q.changed      <= chg;
      work_q.above_high   <= code_q > high_code;
      work_q.below_low    <= code_q < low_code;
    end
    if (cmd_i.out_load) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.item_ok  = (32'(in_slot_i) < SLOT_COUNT) && enable_q[in_slot_i];
  assign status_o.div_done = !div_busy;
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign result_o          = res_q;

endmodule

`default_nettype wire

>>> sv/msm_ctrl.sv
`default_nettype none

module msm_ctrl import msm_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire dp_status_t status_i,
  output ctrl_cmd_t       cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        accept;

  assign accept = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && status_i.item_ok) begin
          state_d = ST_READ;
        end
      end
      ST_READ:   state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_DIVIDE;
      ST_DIVIDE: begin
        if (status_i.div_done) begin
          state_d = ST_OUTPUT;
        end
      end
      ST_OUTPUT: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = accept && status_i.item_ok;
      end
      ST_READ:   cmd_o.mem_read = 1'b1;
      ST_UPDATE: cmd_o.update   = 1'b1;
      ST_DIVIDE: ;
      ST_OUTPUT: cmd_o.out_load = status_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/multichannel_sample_monitor_unit.sv
// Channel  | Direction | Carries
// sample_i | in        | slot, sample_code
// result_o | out       | slot, code, minimum, maximum, average, change, flags
// cfg_*_i  | in        | register index and write data, no read-back
//
// An enabled sample passes from its transfer through capture, the history read,
// the state update, the serial divider that forms the mean as a W-bit quotient,
// where W = 12 + clog2(HISTORY_DEPTH + 1), and the output load that registers
// its result. Samples for disabled slots are dropped in the cycle they arrive.
// Reset is asynchronous and active low; the history memory needs no clearing.
// A held result blocks only the finishing step of the next sample.
`default_nettype none

module multichannel_sample_monitor_unit import msm_pkg::*; #(
  parameter int SLOT_COUNT    = DefSlotCount,
  parameter int HISTORY_DEPTH = DefHistoryDepth
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  msm_sample_if.sink               sample_i,
  msm_result_if.source             result_o
);

  // The controller sequences each enabled sample through a history read, the state
  // update, the division and the output load; the datapath owns all storage.
  ctrl_cmd_t  cmd;
  dp_status_t status;
  result_t    result;
  logic       out_valid;

  msm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_i.valid),
    .in_ready_o (sample_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  msm_datapath #(
    .SLOT_COUNT    (SLOT_COUNT),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_slot_i   (sample_i.slot),
    .in_code_i   (sample_i.sample_code),
    .out_ready_i (result_o.ready),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid),
    .result_o    (result)
  );

  // The output register drives the result channel directly, so each transfer
  // there frees it for the next sample.
  assign result_o.valid        = out_valid;
  assign result_o.result_slot  = result.result_slot;
  assign result_o.current_code = result.current_code;
  assign result_o.minimum_code = result.minimum_code;
  assign result_o.maximum_code = result.maximum_code;
  assign result_o.average_code = result.average_code;
  assign result_o.change_size  = result.change_size;
  assign result_o.changed      = result.changed;
  assign result_o.above_high   = result.above_high;
  assign result_o.below_low    = result.below_low;

endmodule

`default_nettype wire
